[rtl/rsw_pkg.sv]
`timescale 1ns / 1ps

package rsw_pkg;

  localparam int unsigned MaxLineDefault = 4096;

  localparam int unsigned CoordW = 12;
  localparam int unsigned PosW   = 13;
  localparam int unsigned CountW = 5;
  localparam int unsigned ColorW = 8;
  localparam int unsigned PaddrW = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [ColorW-1:0] RunMark    = 8'hE0;
  localparam logic [ColorW-1:0] ClearColor = 8'hFF;

  localparam logic [2:0] RegWindowStart = 3'd0;
  localparam logic [2:0] RegWindowEnd   = 3'd1;
  localparam logic [2:0] RegMaskEnable  = 3'd2;
  localparam logic [2:0] RegDestXStart  = 3'd3;
  localparam logic [2:0] RegDestRow     = 3'd4;

  typedef struct packed {
    logic [CoordW-1:0] window_start;
    logic [CoordW-1:0] window_end;
    logic              mask_enable;
    logic [CoordW-1:0] dest_x_start;
    logic [CoordW-1:0] dest_row;
  } cfg_t;

  typedef struct packed {
    logic [PosW-1:0]   pos;
    logic [CountW-1:0] k;
    logic [CountW-1:0] cnt;
    logic [CoordW-1:0] win_start;
    logic [CoordW-1:0] win_end;
    logic [CoordW-1:0] dest_x;
  } step_req_t;

  typedef struct packed {
    logic            in_win;
    logic            final_step;
    logic            last_pixel;
    logic [PosW-1:0] pixel_x;
    logic [PosW-1:0] pos_next;
    logic            past_end;
  } step_res_t;

endpackage

[rtl/rle_scanline_window_expander_top.sv]
`timescale 1ns / 1ps
// A literal byte is taken while idle and then makes one pass of the position unit.
// A colour byte after a run code of count N steps through N positions, one position each, whether in
// the window or not; each pixel word is registered on its position step and is valid in the cycle after.
// Run codes, end codes and bytes of a finished line are taken while idle and start no run.
// A full output register stalls the run at a position in the window until the word is taken.
// Reset is asynchronous and active low; the line starts finished, awaiting a line start.

module rle_scanline_window_expander_top #(
  parameter int unsigned MAX_LINE = rsw_pkg::MaxLineDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsw_pkg::PaddrW-1:0]  paddr,
  input  logic [rsw_pkg::DataW-1:0]   pwdata,
  output logic [rsw_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rsw_pkg::ColorW-1:0]  rle_byte_i,
  input  logic                        line_start_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rsw_pkg::ColorW-1:0]  pixel_value_o,
  output logic [rsw_pkg::PosW-1:0]    pixel_x_o,
  output logic [rsw_pkg::CoordW-1:0]  pixel_y_o,
  output logic                        write_enable_o,
  output logic                        last_of_run_o
);
  import rsw_pkg::*;

  cfg_t      cfg;
  step_req_t req;
  step_res_t res;

  rsw_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  rsw_pos_unit u_pos_unit (
    .req_i(req),
    .res_o(res)
  );

  rsw_ctrl #(
    .MAX_LINE(MAX_LINE)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rle_byte_i    (rle_byte_i),
    .line_start_i  (line_start_i),
    .req_o         (req),
    .res_i         (res),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_value_o (pixel_value_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .write_enable_o(write_enable_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

[rtl/rsw_regs.sv]
`timescale 1ns / 1ps

module rsw_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rsw_pkg::PaddrW-1:0]   paddr,
  input  logic [rsw_pkg::DataW-1:0]    pwdata,
  output logic [rsw_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  output rsw_pkg::cfg_t                cfg_o
);
  import rsw_pkg::*;

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[PaddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegWindowStart: cfg_d.window_start = pwdata[CoordW-1:0];
        RegWindowEnd:   cfg_d.window_end   = pwdata[CoordW-1:0];
        RegMaskEnable:  cfg_d.mask_enable  = pwdata[0];
        RegDestXStart:  cfg_d.dest_x_start = pwdata[CoordW-1:0];
        RegDestRow:     cfg_d.dest_row     = pwdata[CoordW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegWindowStart: prdata = DataW'(cfg_q.window_start);
      RegWindowEnd:   prdata = DataW'(cfg_q.window_end);
      RegMaskEnable:  prdata = DataW'(cfg_q.mask_enable);
      RegDestXStart:  prdata = DataW'(cfg_q.dest_x_start);
      RegDestRow:     prdata = DataW'(cfg_q.dest_row);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_start <= '0;
      cfg_q.window_end   <= '1;
      cfg_q.mask_enable  <= 1'b0;
      cfg_q.dest_x_start <= '0;
      cfg_q.dest_row     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/rsw_pos_unit.sv]
`timescale 1ns / 1ps

module rsw_pos_unit (
  input  rsw_pkg::step_req_t req_i,
  output rsw_pkg::step_res_t res_o
);
  import rsw_pkg::*;

  logic [PosW:0]   p;
  logic [PosW-1:0] p_next;

  assign p      = {1'b0, req_i.pos} + (PosW+1)'(req_i.k);
  assign p_next = p[PosW-1:0] + PosW'(1);

  assign res_o.in_win     = (p >= {2'b00, req_i.win_start}) && (p <= {2'b00, req_i.win_end});
  assign res_o.final_step = (req_i.k == (req_i.cnt - CountW'(1)));
  assign res_o.last_pixel = res_o.final_step || (p == {2'b00, req_i.win_end});
  assign res_o.pixel_x    = {1'b0, req_i.dest_x} + p[PosW-1:0] - {1'b0, req_i.win_start};
  assign res_o.pos_next   = p_next;
  assign res_o.past_end   = p_next > {1'b0, req_i.win_end};

endmodule

[rtl/rsw_ctrl.sv]
`timescale 1ns / 1ps

module rsw_ctrl #(
  parameter int unsigned MAX_LINE = rsw_pkg::MaxLineDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rsw_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rsw_pkg::ColorW-1:0]  rle_byte_i,
  input  logic                        line_start_i,
  output rsw_pkg::step_req_t          req_o,
  input  rsw_pkg::step_res_t          res_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rsw_pkg::ColorW-1:0]  pixel_value_o,
  output logic [rsw_pkg::PosW-1:0]    pixel_x_o,
  output logic [rsw_pkg::CoordW-1:0]  pixel_y_o,
  output logic                        write_enable_o,
  output logic                        last_of_run_o
);
  import rsw_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;
  localparam logic [CoordW-1:0] LineLast = CoordW'(MAX_LINE - 1);

  logic              state_q, state_d;
  logic              await_q, await_d;
  logic [CountW-1:0] pend_q, pend_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              fin_q, fin_d;
  logic [CountW-1:0] k_q, k_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [ColorW-1:0] color_q, color_d;
  logic              out_valid_q, out_valid_d;

  logic [ColorW-1:0] pix_value_q;
  logic [PosW-1:0]   pix_x_q;
  logic [CoordW-1:0] pix_y_q;
  logic              pix_we_q;
  logic              pix_last_q;

  logic [CoordW-1:0] end_w;
  logic              accept;
  logic              slot_free;
  logic              emit;
  logic              step;
  logic              await_eff;
  logic [CountW-1:0] pend_eff;
  logic [PosW-1:0]   pos_eff;
  logic              fin_eff;

  assign end_w      = (cfg_i.window_end < LineLast) ? cfg_i.window_end : LineLast;
  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign emit       = (state_q == StRun) && res_i.in_win && slot_free;
  assign step       = (state_q == StRun) && (!res_i.in_win || slot_free);

  assign await_eff = line_start_i ? 1'b0 : await_q;
  assign pend_eff  = line_start_i ? '0 : pend_q;
  assign pos_eff   = line_start_i ? '0 : pos_q;
  assign fin_eff   = line_start_i ? 1'b0 : fin_q;

  assign req_o.pos       = pos_q;
  assign req_o.k         = k_q;
  assign req_o.cnt       = cnt_q;
  assign req_o.win_start = cfg_i.window_start;
  assign req_o.win_end   = end_w;
  assign req_o.dest_x    = cfg_i.dest_x_start;

  always_comb begin
    state_d = state_q;
    await_d = await_q;
    pend_d  = pend_q;
    pos_d   = pos_q;
    fin_d   = fin_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    color_d = color_q;
    if (accept) begin
      await_d = await_eff;
      pend_d  = pend_eff;
      pos_d   = pos_eff;
      fin_d   = fin_eff;
      if (!fin_eff) begin
        if (await_eff) begin
          await_d = 1'b0;
          color_d = rle_byte_i;
          if (pend_eff == '0) begin
            fin_d = pos_eff > {1'b0, end_w};
          end else begin
            cnt_d   = pend_eff;
            k_d     = '0;
            state_d = StRun;
          end
        end else if (rle_byte_i == RunMark) begin
          fin_d = 1'b1;
        end else if ((rle_byte_i & RunMark) == RunMark) begin
          pend_d  = rle_byte_i[CountW-1:0];
          await_d = 1'b1;
        end else begin
          color_d = rle_byte_i;
          cnt_d   = CountW'(1);
          k_d     = '0;
          state_d = StRun;
        end
      end
    end
    if (step) begin
      if (res_i.final_step) begin
        pos_d   = res_i.pos_next;
        fin_d   = fin_q || res_i.past_end;
        state_d = StIdle;
      end else begin
        k_d = k_q + CountW'(1);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      await_q     <= 1'b0;
      pend_q      <= '0;
      pos_q       <= '0;
      fin_q       <= 1'b1;
      k_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      await_q     <= await_d;
      pend_q      <= pend_d;
      pos_q       <= pos_d;
      fin_q       <= fin_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d;
    if (emit) begin
      pix_value_q <= color_q;
      pix_x_q     <= res_i.pixel_x;
      pix_y_q     <= cfg_i.dest_row;
      pix_we_q    <= !(cfg_i.mask_enable && (color_q == ClearColor));
      pix_last_q  <= res_i.last_pixel;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = pix_value_q;
  assign pixel_x_o      = pix_x_q;
  assign pixel_y_o      = pix_y_q;
  assign write_enable_o = pix_we_q;
  assign last_of_run_o  = pix_last_q;

`ifndef SYNTHESIS
  a_run_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (cnt_q != '0))
    else $error("run started with a zero count");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (k_q < cnt_q))
    else $error("run index beyond run count");

  a_emit_only_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (out_valid_q && ($past(state_q) == StRun)))
    else $error("pixel word loaded outside a run");

  a_finish_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fin_q) |-> ($past(accept) || ($past(state_q) == StRun)))
    else $error("line finished without a byte or run step");
`endif

endmodule

[tb/sv/rle_window_pixel_checker.sv]
`timescale 1ns / 1ps

module rle_window_pixel_checker #(
  parameter int unsigned MAX_LINE = rsw_pkg::MaxLineDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic                       pready_i,
  input  logic [rsw_pkg::PaddrW-1:0] paddr_i,
  input  logic [rsw_pkg::DataW-1:0]  pwdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [rsw_pkg::ColorW-1:0] rle_byte_i,
  input  logic                       line_start_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [rsw_pkg::ColorW-1:0] pixel_value_i,
  input  logic [rsw_pkg::PosW-1:0]   pixel_x_i,
  input  logic [rsw_pkg::CoordW-1:0] pixel_y_i,
  input  logic                       write_enable_i,
  input  logic                       last_of_run_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         pixels_seen_o
);

  import rsw_pkg::*;

  typedef struct packed {
    logic [ColorW-1:0] value;
    logic [PosW-1:0]   x;
    logic [CoordW-1:0] y;
    logic              we;
    logic              last;
  } pixel_t;

  pixel_t expected_pixels[$];

  logic [CoordW-1:0] win_start;
  logic [CoordW-1:0] win_end;
  logic              mask_on;
  logic [CoordW-1:0] dest_x;
  logic [CoordW-1:0] dest_row;

  logic              awaiting_colour;
  logic [CountW-1:0] run_len;
  logic [PosW-1:0]   src_pos;
  logic              line_done;

  int fails;
  int seen;

  task automatic expand_run(input logic [ColorW-1:0] colour, input int count);
    int line_end;
    int last_pos;
    int p;
    pixel_t px;
    line_end = int'(MAX_LINE) - 1;
    if (int'(win_end) < line_end) begin
      line_end = int'(win_end);
    end
    last_pos = int'(src_pos) + count - 1;
    if (last_pos > line_end) begin
      last_pos = line_end;
    end
    for (int k = 0; k < count; k++) begin
      p = int'(src_pos) + k;
      if (p >= int'(win_start) && p <= line_end) begin
        px.value = colour;
        px.x     = PosW'(int'(dest_x) + p - int'(win_start));
        px.y     = dest_row;
        px.we    = !(mask_on && colour == ClearColor);
        px.last  = (p == last_pos);
        expected_pixels.push_back(px);
      end
    end
    src_pos = PosW'(int'(src_pos) + count);
    if (int'(src_pos) > line_end) begin
      line_done = 1'b1;
    end
  endtask

  task automatic decode_rle_byte(input logic [ColorW-1:0] b, input logic ls);
    if (ls) begin
      src_pos         = '0;
      awaiting_colour = 1'b0;
      run_len         = '0;
      line_done       = 1'b0;
    end
    if (!line_done) begin
      if (awaiting_colour) begin
        awaiting_colour = 1'b0;
        expand_run(b, int'(run_len));
      end else if (b == RunMark) begin
        line_done = 1'b1;
      end else if ((b & RunMark) == RunMark) begin
        run_len         = b[CountW-1:0];
        awaiting_colour = 1'b1;
      end else begin
        expand_run(b, 1);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pixel_t got;
    pixel_t want;
    if (!rst_ni) begin
      win_start       = '0;
      win_end         = 12'hFFF;
      mask_on         = 1'b0;
      dest_x          = '0;
      dest_row        = '0;
      awaiting_colour = 1'b0;
      run_len         = '0;
      src_pos         = '0;
      line_done       = 1'b1;
      fails           = 0;
      seen            = 0;
      expected_pixels.delete();
      fail_count_o  <= 0;
      pending_o     <= 0;
      pixels_seen_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = {pixel_value_i, pixel_x_i, pixel_y_i, write_enable_i, last_of_run_i};
        seen++;
        if (expected_pixels.size() == 0) begin
          if (fails < 10) begin
            $display("ERROR at %0t: unexpected pixel word value %0d x %0d y %0d we %0b last %0b",
                     $time, got.value, got.x, got.y, got.we, got.last);
          end
          fails++;
        end else begin
          want = expected_pixels.pop_front();
          if (got != want) begin
            if (fails < 10) begin
              $display("ERROR at %0t: pixel word %0d mismatch", $time, seen);
              $display("  expected value %0d x %0d y %0d we %0b last %0b",
                       want.value, want.x, want.y, want.we, want.last);
              $display("  actual   value %0d x %0d y %0d we %0b last %0b",
                       got.value, got.x, got.y, got.we, got.last);
            end
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        decode_rle_byte(rle_byte_i, line_start_i);
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PaddrW-1:2])
          RegWindowStart: win_start = pwdata_i[CoordW-1:0];
          RegWindowEnd:   win_end   = pwdata_i[CoordW-1:0];
          RegMaskEnable:  mask_on   = pwdata_i[0];
          RegDestXStart:  dest_x    = pwdata_i[CoordW-1:0];
          RegDestRow:     dest_row  = pwdata_i[CoordW-1:0];
          default: ;
        endcase
      end
      fail_count_o  <= fails;
      pending_o     <= expected_pixels.size();
      pixels_seen_o <= seen;
    end
  end

endmodule

[tb/sv/rle_scanline_window_expander_top_tb.sv]
`timescale 1ns / 1ps

module rle_scanline_window_expander_top_tb;

  import rsw_pkg::*;

  localparam int CycleLimit  = 600000;
  localparam int DrainCycles = 40;
  localparam int HoldCycles  = 400;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [PaddrW-1:0] paddr        = '0;
  logic [DataW-1:0]  pwdata       = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic [ColorW-1:0] rle_byte_i   = '0;
  logic              line_start_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [ColorW-1:0] pixel_value_o;
  logic [PosW-1:0]   pixel_x_o;
  logic [CoordW-1:0] pixel_y_o;
  logic              write_enable_o;
  logic              last_of_run_o;

  int fail_count;
  int pending;
  int pixels_seen;

  int send_idle_pct = 31;
  int recv_idle_pct = 60;
  bit hold_off_on   = 1'b0;
  bit pressure_done = 1'b0;
  int hold_count    = 0;
  int cycle_count   = 0;
  int words_sent    = 0;
  int settings_run  = 0;

  rle_scanline_window_expander_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rle_byte_i     (rle_byte_i),
    .line_start_i   (line_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_value_o  (pixel_value_o),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .write_enable_o (write_enable_o),
    .last_of_run_o  (last_of_run_o)
  );

  rle_window_pixel_checker pixel_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .rle_byte_i     (rle_byte_i),
    .line_start_i   (line_start_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_value_i  (pixel_value_o),
    .pixel_x_i      (pixel_x_o),
    .pixel_y_i      (pixel_y_o),
    .write_enable_i (write_enable_o),
    .last_of_run_i  (last_of_run_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .pixels_seen_o  (pixels_seen)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d pixel words outstanding", cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The long hold-off lets the output side back up until the input word stalls.
  always @(posedge clk_i) begin
    if (hold_off_on && hold_count < HoldCycles) begin
      out_ready_i <= 1'b0;
      hold_count  <= hold_count + 1;
    end else begin
      if (!hold_off_on) begin
        hold_count <= 0;
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_word(input logic [ColorW-1:0] b, input logic ls);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    rle_byte_i   <= b;
    line_start_i <= ls;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [CoordW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {(DataW - CoordW)'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_window(input logic [CoordW-1:0] ws, input logic [CoordW-1:0] we,
                                input logic mask, input logic [CoordW-1:0] dx,
                                input logic [CoordW-1:0] dr);
    reg_write(RegWindowStart, ws);
    reg_write(RegWindowEnd, we);
    reg_write(RegMaskEnable, {{(CoordW - 1){1'b0}}, mask});
    reg_write(RegDestXStart, dx);
    reg_write(RegDestRow, dr);
    settings_run++;
  endtask

  function automatic logic [CoordW-1:0] dest_coord();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 12'hFFF;
      default: return CoordW'($urandom);
    endcase
  endfunction

  function automatic logic [ColorW-1:0] run_colour();
    return ($urandom_range(0, 4) == 0) ? ClearColor : ColorW'($urandom);
  endfunction

  task automatic random_window();
    int ws;
    int we;
    case ($urandom_range(0, 5))
      3: begin
        ws = 0;
        we = 4095;
      end
      4: begin
        ws = $urandom_range(20, 200);
        we = $urandom_range(0, ws - 1);
      end
      5: begin
        ws = 0;
        we = 0;
      end
      default: begin
        ws = $urandom_range(0, 40);
        we = ws + $urandom_range(0, 250);
      end
    endcase
    program_window(CoordW'(ws), CoordW'(we), 1'($urandom_range(0, 1)), dest_coord(),
                   dest_coord());
  endtask

  // Mostly literals and run pairs, with a few end codes and stray words mixed in.
  task automatic send_line(input int tokens);
    int   sel;
    logic ls;
    ls = 1'b1;
    for (int t = 0; t < tokens; t++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        send_word(ColorW'($urandom_range(0, 8'hDF)), ls);
      end else if (sel < 88) begin
        send_word(RunMark | ColorW'($urandom_range(1, 31)), ls);
        send_word(run_colour(), 1'b0);
      end else if (sel < 94) begin
        send_word(RunMark, ls);
      end else begin
        send_word(ColorW'($urandom), 1'($urandom_range(0, 9) == 0));
      end
      ls = 1'b0;
    end
    if ($urandom_range(0, 1) == 1) begin
      send_word(RunMark, 1'b0);
    end
  endtask

  task automatic far_line();
    send_word(8'hFF, 1'b1);
    send_word(run_colour(), 1'b0);
    for (int r = 1; r < 134; r++) begin
      send_word(8'hFF, 1'b0);
      send_word(run_colour(), 1'b0);
    end
    send_word(8'h12, 1'b0);
  endtask

  initial begin : stimulus
    int target;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(8'h10, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(8'hDF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(RunMark, 1'b0);
    send_word(8'hE1, 1'b0);
    send_word(ClearColor, 1'b0);
    send_word(8'hE5, 1'b0);
    send_word(8'hE3, 1'b0);
    send_word(8'hE4, 1'b0);
    send_word(8'h7F, 1'b1);
    send_word(RunMark, 1'b0);
    send_word(8'h20, 1'b0);
    send_word(8'hAA, 1'b1);
    drain();
    program_window(12'd3, 12'd6, 1'b1, 12'hFFF, 12'hFFF);
    send_word(8'hE8, 1'b1);
    send_word(ClearColor, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h02, 1'b0);
    drain();
    program_window(12'd10, 12'd5, 1'b0, 12'd0, 12'd0);
    send_word(8'h11, 1'b1);
    send_word(8'hE9, 1'b0);
    send_word(8'h22, 1'b0);
    send_word(8'h33, 1'b0);
    send_word(RunMark, 1'b1);
    send_word(8'h44, 1'b0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct <= (ph == 0) ? 31 : (ph == 1) ? 60 : 0;
      recv_idle_pct <= (ph == 0) ? 60 : (ph == 1) ? 31 : 0;
      target = words_sent + 25;
      while (words_sent < target) begin
        random_window();
        if (!pressure_done) begin
          hold_off_on   <= 1'b1;
          pressure_done = 1'b1;
        end
        send_line($urandom_range(3, 12));
        drain();
        hold_off_on <= 1'b0;
      end
    end

    program_window(CoordW'(4095 - $urandom_range(0, 60)), 12'hFFF, 1'($urandom_range(0, 1)),
                   dest_coord(), dest_coord());
    far_line();
    drain();

    $display("Run covered %0d input words and %0d pixel words over %0d register settings,",
             words_sent, pixels_seen, settings_run);
    $display("including a far window at the end of the line and a long output hold-off.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches in total", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rsw_pkg.sv
rtl/rsw_regs.sv
rtl/rsw_pos_unit.sv
rtl/rsw_ctrl.sv
rtl/rle_scanline_window_expander_top.sv
tb/sv/rle_window_pixel_checker.sv
tb/sv/rle_scanline_window_expander_top_tb.sv
